// ----- hw/rtl/psev_pkg.sv -----
// Shared definitions for the postfix stack evaluator.
// Status codes, character codes, word width and the divider response type.
// No dependencies.
`default_nettype none

package psev_pkg;

	localparam int WORD_W = 32;
	localparam int STACK_DEPTH_DEF = 16;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_DIVZERO   = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/postfix_stack_evaluator_core.sv -----
// Postfix expression evaluator: top level with sequencer, stack memory and divider.
// Depends on psev_pkg, psev_stack_mem and psev_div.
//
//  channel | signals                          | direction
//  input   | in_valid, in_stall, symbol, last | in, stall out
//  output  | out_valid, out_stall, value, status | out, stall in
//
// Digits and ignored operators finish in idle; +, - and * pass execute and write-back;
// divide adds a divider wait (one quotient bit per cycle) unless the divisor is zero;
// a last character adds the result transaction. One item is in work at a time.
// Reset clears state, stack depth, error status and the output valid flag; no memory sweep.
// A held output stalls only an item whose result would overwrite it.
`default_nettype none

module postfix_stack_evaluator_core
	import psev_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        symbol,
	input  wire logic              last,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [WORD_W-1:0] value,
	output logic      [2:0]        status
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_DIVW = 3'd2;
	localparam logic [2:0] S_WB   = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]        state_q;
	logic [DW-1:0]     depth_q;
	logic [2:0]        err_q;
	logic [WORD_W-1:0] top_q;
	logic [WORD_W-1:0] res_q;
	logic [7:0]        sym_q;
	logic              last_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] value_q;
	logic [2:0]        status_q;

	logic              in_acc;
	logic              is_digit;
	logic              emit_go;
	logic [DW-1:0]     depth_m2;
	logic [WORD_W-1:0] prod;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [WORD_W-1:0] mem_rdata;

	logic              div_start;
	div_rsp_t          div_rsp;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign is_digit = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
	assign emit_go  = (state_q == S_EMIT) && !(out_valid_q && out_stall);
	assign depth_m2 = depth_q - DW'(2);
	assign prod     = mem_rdata * top_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = depth_q[AW-1:0];
		mem_wdata = WORD_W'(symbol - CH_ZERO);
		mem_re    = 1'b0;
		if (in_acc && is_digit && (depth_q < DW'(STACK_DEPTH))) begin
			mem_we = 1'b1;
		end else if (state_q == S_WB) begin
			mem_we    = 1'b1;
			mem_waddr = depth_m2[AW-1:0];
			mem_wdata = res_q;
		end
		if (in_acc && !is_digit && (depth_q >= DW'(2))) begin
			mem_re = 1'b1;
		end
	end

	assign div_start = (state_q == S_EXEC) && (sym_q != CH_PLUS) && (sym_q != CH_MINUS)
		&& (sym_q != CH_STAR) && (top_q != '0);

	psev_stack_mem #(
		.DEPTH(STACK_DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(depth_m2[AW-1:0]),
		.rdata(mem_rdata)
	);

	psev_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mem_rdata),
		.divisor (top_q),
		.rsp     (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (is_digit) begin
							if (depth_q < DW'(STACK_DEPTH)) begin
								depth_q <= depth_q + DW'(1);
							end else if (err_q == ST_OK) begin
								err_q <= ST_OVERFLOW;
							end
							state_q <= last ? S_EMIT : S_IDLE;
						end else if (depth_q >= DW'(2)) begin
							state_q <= S_EXEC;
						end else begin
							if ((depth_q == DW'(1)) && (err_q == ST_OK)) begin
								err_q <= ST_UNDERFLOW;
							end
							state_q <= last ? S_EMIT : S_IDLE;
						end
					end
				end
				S_EXEC: begin
					if (div_start) begin
						state_q <= S_DIVW;
					end else begin
						if ((sym_q != CH_PLUS) && (sym_q != CH_MINUS) && (sym_q != CH_STAR)
							&& (err_q == ST_OK)) begin
							err_q <= ST_DIVZERO;
						end
						state_q <= S_WB;
					end
				end
				S_DIVW: begin
					if (div_rsp.done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					depth_q <= depth_q - DW'(1);
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (emit_go) begin
						depth_q <= '0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sym_q  <= symbol;
			last_q <= last;
			if (is_digit && (depth_q < DW'(STACK_DEPTH))) begin
				top_q <= WORD_W'(symbol - CH_ZERO);
			end
		end
		if (state_q == S_EXEC) begin
			case (sym_q)
				CH_PLUS:  res_q <= mem_rdata + top_q;
				CH_MINUS: res_q <= mem_rdata - top_q;
				CH_STAR:  res_q <= prod;
				default:  res_q <= '0;
			endcase
		end else if ((state_q == S_DIVW) && div_rsp.done) begin
			res_q <= div_rsp.quot;
		end
		if (state_q == S_WB) begin
			top_q <= res_q;
		end
		if (emit_go) begin
			if (depth_q == '0) begin
				value_q  <= '0;
				status_q <= (err_q != ST_OK) ? err_q : ST_EMPTY;
			end else begin
				value_q  <= top_q;
				status_q <= err_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIVW)
		else $error("divider finished outside its wait state");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (depth_q == '0) && (err_q == ST_OK) && out_valid)
		else $error("result transaction did not clear the stack");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_EMPTY)
		else $error("status code out of range");

	a_exec_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> depth_q >= DW'(2))
		else $error("operator executed without two operands");

endmodule

`default_nettype wire

// ----- hw/rtl/psev_stack_mem.sv -----
// Operand stack storage: one write port, one read port, registered read data.
// Depends on psev_pkg for the word width.
`default_nettype none

module psev_stack_mem
	import psev_pkg::*;
#(
	parameter int DEPTH = STACK_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [WORD_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/psev_div.sv -----
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on psev_pkg for the word width and the response struct.
`default_nettype none

module psev_div
	import psev_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [WORD_W-1:0] dividend,
	input  wire logic [WORD_W-1:0] divisor,
	output div_rsp_t               rsp
);

	localparam int CW = $clog2(WORD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic              neg_q;
	logic [WORD_W-1:0] bmag_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W+1:0] diff;

	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, bmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			quo_q  <= dividend[WORD_W-1] ? (~dividend + WORD_W'(1)) : dividend;
			bmag_q <= divisor[WORD_W-1] ? (~divisor + WORD_W'(1)) : divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (!diff[WORD_W+1]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? (~quo_q + WORD_W'(1)) : quo_q;

endmodule

`default_nettype wire
